// ===== src/aiks_pkg.sv =====
package aiks_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_LINK_LENGTH      = 2'd0;
  localparam logic [1:0] REG_BASE_OFFSET      = 2'd1;
  localparam logic [1:0] REG_STEPS_PER_DEGREE = 2'd2;

  localparam logic [11:0] LINK_LENGTH_RESET      = 12'd1920;
  localparam logic [11:0] BASE_OFFSET_RESET      = 12'd656;
  localparam logic [19:0] STEPS_PER_DEGREE_RESET = 20'd167481;

  // Datapath widths
  localparam int CW    = 26;  // CORDIC vector component
  localparam int AW    = 32;  // CORDIC angle accumulator, 2^-24 degree
  localparam int THW   = 35;  // joint angle
  localparam int STEPW = 18;

  localparam logic [STEPW-1:0] STEP_MAX = '1;
  localparam logic signed [THW-1:0] DEG90  = 35'sd1509949440;
  localparam logic signed [THW-1:0] DEG180 = 35'sd3019898880;

  // atan(2^-i) in 2^-24 degree
  localparam logic signed [AW-1:0] ATAN_DEG [32] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934, 32'sd30029717, 32'sd15018523, 32'sd7509719,
    32'sd3754917, 32'sd1877465, 32'sd938734, 32'sd469367,
    32'sd234684, 32'sd117342, 32'sd58671, 32'sd29335,
    32'sd14668, 32'sd7334, 32'sd3667, 32'sd1834,
    32'sd917, 32'sd458, 32'sd229, 32'sd115,
    32'sd57, 32'sd29, 32'sd14, 32'sd7,
    32'sd4, 32'sd2, 32'sd1, 32'sd0
  };

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [AW-1:0] ang;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  // Sideband through the first root
  typedef struct packed {
    logic signed [13:0] x;
    logic [13:0]        ay;
    logic signed [13:0] z;
    logic               origin;
  } side1_t;

  // Sideband through the second root
  typedef struct packed {
    logic signed [13:0] x;
    logic [13:0]        ay;
    logic signed [13:0] z;
    logic               origin;
    logic [21:0]        rr;
  } side2_t;

  // Sideband through the third root
  typedef struct packed {
    logic signed [13:0] x;
    logic [13:0]        ay;
    logic [13:0]        az;
    logic               z_pos;
    logic [21:0]        rr;
    logic [22:0]        rs;
    logic               unreach;
  } side3_t;

  typedef struct packed {
    logic z_pos;
    logic unreach;
  } cside_t;

  typedef struct packed {
    logic             reachable;
    logic             base_dir;
    logic [STEPW-1:0] base_steps;
    logic             shoulder_dir;
    logic [STEPW-1:0] shoulder_steps;
    logic             elbow_dir;
    logic [STEPW-1:0] elbow_steps;
  } result_t;

endpackage

// ===== src/aiks_if.sv =====
interface aiks_target_if;
  logic              valid;
  logic              ready;
  logic signed [13:0] target_x;
  logic signed [13:0] target_y;
  logic signed [13:0] target_z;
  modport source (output valid, target_x, target_y, target_z, input ready);
  modport sink (input valid, target_x, target_y, target_z, output ready);
endinterface

interface aiks_result_if;
  logic        valid;
  logic        ready;
  logic        reachable;
  logic        base_dir;
  logic [17:0] base_steps;
  logic        shoulder_dir;
  logic [17:0] shoulder_steps;
  logic        elbow_dir;
  logic [17:0] elbow_steps;
  modport source (output valid, reachable, base_dir, base_steps, shoulder_dir,
                  shoulder_steps, elbow_dir, elbow_steps, input ready);
  modport sink (input valid, reachable, base_dir, base_steps, shoulder_dir,
                shoulder_steps, elbow_dir, elbow_steps, output ready);
endinterface

interface aiks_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/aiks_sqrt_cell.sv =====
module aiks_sqrt_cell #(
  parameter int IN_W   = 44,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                valid_in,
  input  logic [IN_W-1:0]     rad_in,
  input  logic [IN_W/2+1:0]   rem_in,
  input  logic [IN_W/2-1:0]   root_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                valid_out,
  output logic [IN_W-1:0]     rad_out,
  output logic [IN_W/2+1:0]   rem_out,
  output logic [IN_W/2-1:0]   root_out,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int OUT_W = IN_W / 2;

  logic [OUT_W+1:0] cur;
  logic [OUT_W+1:0] trial;
  logic             fits;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    cur   = {rem_in[OUT_W-1:0], rad_in[IN_W-1 -: 2]};
    trial = {root_in, 2'b01};
    fits  = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_out  <= rad_in << 2;
      rem_out  <= fits ? (cur - trial) : cur;
      root_out <= {root_in[OUT_W-2:0], fits};
      side_out <= side_in;
    end
  end

endmodule

// ===== src/aiks_isqrt.sv =====
module aiks_isqrt #(
  parameter int IN_W   = 44,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                valid_in,
  input  logic [IN_W-1:0]     rad,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                valid_out,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int OUT_W = IN_W / 2;

  logic              v_c    [OUT_W+1];
  logic [IN_W-1:0]   rad_c  [OUT_W+1];
  logic [OUT_W+1:0]  rem_c  [OUT_W+1];
  logic [OUT_W-1:0]  root_c [OUT_W+1];
  logic [SIDE_W-1:0] side_c [OUT_W+1];

  assign v_c[0]    = valid_in;
  assign rad_c[0]  = rad;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign side_c[0] = side_in;

  // One root bit per cell, most significant first
  for (genvar k = 0; k < OUT_W; k++) begin : g_cell
    aiks_sqrt_cell #(.IN_W(IN_W), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .valid_in (v_c[k]),
      .rad_in   (rad_c[k]),
      .rem_in   (rem_c[k]),
      .root_in  (root_c[k]),
      .side_in  (side_c[k]),
      .valid_out(v_c[k+1]),
      .rad_out  (rad_c[k+1]),
      .rem_out  (rem_c[k+1]),
      .root_out (root_c[k+1]),
      .side_out (side_c[k+1])
    );
  end

  assign valid_out = v_c[OUT_W] & (rad_c[OUT_W] == '0);
  assign root      = root_c[OUT_W];
  assign side_out  = side_c[OUT_W];

endmodule

// ===== src/aiks_cordic_cell.sv =====
module aiks_cordic_cell
  import aiks_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   valid_in,
  input  lanes_t lanes_in,
  input  cside_t side_in,
  output logic   valid_out,
  output lanes_t lanes_out,
  output cside_t side_out
);

  lanes_t lanes_next;

  // Rotate each vector toward the positive axis
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (lanes_in[l].b >= 0) begin
        lanes_next[l].a   = lanes_in[l].a + (lanes_in[l].b >>> IDX);
        lanes_next[l].b   = lanes_in[l].b - (lanes_in[l].a >>> IDX);
        lanes_next[l].ang = lanes_in[l].ang + ATAN_DEG[IDX];
      end else begin
        lanes_next[l].a   = lanes_in[l].a - (lanes_in[l].b >>> IDX);
        lanes_next[l].b   = lanes_in[l].b + (lanes_in[l].a >>> IDX);
        lanes_next[l].ang = lanes_in[l].ang - ATAN_DEG[IDX];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lanes_out <= lanes_next;
      side_out  <= side_in;
    end
  end

endmodule

// ===== src/arm_inverse_kinematics_steps_unit.sv =====
// Inverse kinematics for a three joint arm with two equal links.
// target: one item is a point (target_x, target_y, target_z) in 1/16 mm,
//   taken when valid and ready are both high.
// result: one item per point: reachable flag, then direction and saturated
//   step count for base, shoulder and elbow. All fields are zero when the
//   point is at the origin axis or out of reach.
// cfg: writes link_length (index 0), base_offset (1), steps_per_degree (2);
//   ready is always high. Write only while no item is in flight.
// Throughput: one item per cycle while the skid entry is empty. The path from
//   acceptance to result valid runs through three bit-per-cell square root chains
//   (22, 23 and 21 cells) and the CORDIC chain of CORDIC_STAGES cells.
// Reset (rst, synchronous) empties the pipeline and loads the default
//   registers: link 1920, offset 656, steps per degree 167481.
// Receiver stall: a second output register holds one more item, then the
//   whole pipeline and target.ready hold until result.ready returns.
module arm_inverse_kinematics_steps_unit
  import aiks_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  aiks_target_if.sink          target,
  aiks_result_if.source        result,
  aiks_cfg_if.sink             cfg
);

  logic [11:0] link_length;
  logic [11:0] base_offset;
  logic [19:0] steps_per_degree;

  logic adv;

  // Write configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_length      <= LINK_LENGTH_RESET;
      base_offset      <= BASE_OFFSET_RESET;
      steps_per_degree <= STEPS_PER_DEGREE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LINK_LENGTH:      link_length      <= cfg.data[11:0];
        REG_BASE_OFFSET:      base_offset      <= cfg.data[11:0];
        REG_STEPS_PER_DEGREE: steps_per_degree <= cfg.data;
        default: ;
      endcase
    end
  end

  // Register the input item
  logic               v0;
  logic signed [13:0] x0, y0, z0;

  assign target.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= target.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0 <= target.target_x;
      y0 <= target.target_y;
      z0 <= target.target_z;
    end
  end

  // Square the horizontal coordinates
  logic               v1;
  logic [26:0]        xsq1, ysq1;
  logic signed [27:0] xsq_full, ysq_full;
  side1_t             s1;

  assign xsq_full = x0 * x0;
  assign ysq_full = y0 * y0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xsq1      <= xsq_full[26:0];
      ysq1      <= ysq_full[26:0];
      s1.x      <= x0;
      s1.ay     <= y0[13] ? 14'(-y0) : 14'(y0);
      s1.z      <= z0;
      s1.origin <= (x0 == '0) && (y0 == '0);
    end
  end

  // Horizontal radius
  logic        vq1;
  logic [43:0] rad1;
  logic [21:0] r0;
  side1_t      sq1;

  assign rad1 = {({1'b0, xsq1} + {1'b0, ysq1}), 16'b0};

  aiks_isqrt #(.IN_W(44), .SIDE_W($bits(side1_t))) u_sqrt_r0 (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .valid_in (v1),
    .rad      (rad1),
    .side_in  (s1),
    .valid_out(vq1),
    .root     (r0),
    .side_out (sq1)
  );

  // Pull in by the base offset, square z
  logic               v2;
  side2_t             s2;
  logic [26:0]        zsq2;
  logic signed [22:0] rdiff;
  logic signed [27:0] zsq_full;

  assign rdiff    = $signed({1'b0, r0}) - $signed({3'b0, base_offset, 8'b0});
  assign zsq_full = sq1.z * sq1.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= vq1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.x      <= sq1.x;
      s2.ay     <= sq1.ay;
      s2.z      <= sq1.z;
      s2.origin <= sq1.origin;
      s2.rr     <= rdiff[22] ? 22'(-rdiff) : rdiff[21:0];
      zsq2      <= zsq_full[26:0];
    end
  end

  // Square the pulled-in radius
  logic        v3;
  side2_t      s3;
  logic [43:0] rrsq3;
  logic [26:0] zsq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3    <= s2;
      rrsq3 <= s2.rr * s2.rr;
      zsq3  <= zsq2;
    end
  end

  // Distance to the pulled-in point
  logic        vq2;
  logic [45:0] rad2;
  logic [22:0] rs;
  side2_t      sq2;

  assign rad2 = {2'b0, rrsq3} + {3'b0, zsq3, 16'b0};

  aiks_isqrt #(.IN_W(46), .SIDE_W($bits(side2_t))) u_sqrt_rs (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .valid_in (v3),
    .rad      (rad2),
    .side_in  (s3),
    .valid_out(vq2),
    .root     (rs),
    .side_out (sq2)
  );

  // Reach test and square of the distance
  logic        v4;
  side3_t      s4;
  logic [45:0] rssq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= vq2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4.x       <= sq2.x;
      s4.ay      <= sq2.ay;
      s4.az      <= sq2.z[13] ? 14'(-sq2.z) : 14'(sq2.z);
      s4.z_pos   <= !sq2.z[13] && (sq2.z != '0);
      s4.rr      <= sq2.rr;
      s4.rs      <= rs;
      s4.unreach <= sq2.origin || (rs == '0) || (rs > {2'b0, link_length, 9'b0});
      rssq4      <= rs * rs;
    end
  end

  // Radicand of the triangle height
  logic        v5;
  side3_t      s5;
  logic [41:0] rad3;
  logic [23:0] lsq;

  assign lsq = link_length * link_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5   <= s4;
      rad3 <= s4.unreach ? '0 : ({lsq, 18'b0} - rssq4[41:0]);
    end
  end

  // Height of the link triangle
  logic        vq3;
  logic [20:0] h;
  side3_t      sq3;

  aiks_isqrt #(.IN_W(42), .SIDE_W($bits(side3_t))) u_sqrt_h (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .valid_in (v5),
    .rad      (rad3),
    .side_in  (s5),
    .valid_out(vq3),
    .root     (h),
    .side_out (sq3)
  );

  // CORDIC chain: lane 0 yaw, lane 1 half elbow, lane 2 shoulder term
  logic   cv [CORDIC_STAGES+1];
  lanes_t cl [CORDIC_STAGES+1];
  cside_t cs [CORDIC_STAGES+1];

  assign cv[0]        = vq3;
  assign cl[0][0].a   = {4'b0, sq3.ay, 8'b0};
  assign cl[0][0].b   = {{4{sq3.x[13]}}, sq3.x, 8'b0};
  assign cl[0][0].ang = '0;
  assign cl[0][1].a   = {3'b0, sq3.rs};
  assign cl[0][1].b   = {5'b0, h};
  assign cl[0][1].ang = '0;
  assign cl[0][2].a   = {4'b0, sq3.az, 8'b0};
  assign cl[0][2].b   = {4'b0, sq3.rr};
  assign cl[0][2].ang = '0;
  assign cs[0].z_pos   = sq3.z_pos;
  assign cs[0].unreach = sq3.unreach;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    aiks_cordic_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .valid_in (cv[i]),
      .lanes_in (cl[i]),
      .side_in  (cs[i]),
      .valid_out(cv[i+1]),
      .lanes_out(cl[i+1]),
      .side_out (cs[i+1])
    );
  end

  // Joint angles
  logic                  v6;
  logic                  unreach6;
  logic signed [THW-1:0] th1, th2, th3;
  logic signed [THW-1:0] yaw, half, ash, th2_c;
  lanes_t                lf;

  assign lf    = cl[CORDIC_STAGES];
  assign yaw   = THW'(lf[0].ang);
  assign half  = THW'(lf[1].ang);
  assign ash   = THW'(lf[2].ang);
  assign th2_c = cs[CORDIC_STAGES].z_pos ? (ash - half) : (DEG180 - ash - half);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unreach6 <= cs[CORDIC_STAGES].unreach;
      th1      <= DEG90 - yaw;
      th2      <= th2_c;
      th3      <= (half <<< 1) + th2_c - DEG90;
    end
  end

  // Scale by steps per degree
  logic        v7;
  logic        unreach7;
  logic [2:0]  dir7;
  logic [53:0] prod7 [3];
  logic [33:0] mag1, mag2, mag3;

  assign mag1 = th1[THW-1] ? 34'(-th1) : th1[33:0];
  assign mag2 = th2[THW-1] ? 34'(-th2) : th2[33:0];
  assign mag3 = th3[THW-1] ? 34'(-th3) : th3[33:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unreach7 <= unreach6;
      dir7     <= {th3[THW-1], th2[THW-1], th1[THW-1]};
      prod7[0] <= mag1 * steps_per_degree;
      prod7[1] <= mag2 * steps_per_degree;
      prod7[2] <= mag3 * steps_per_degree;
    end
  end

  // Saturate and mask unreachable points
  logic             v8;
  result_t          res8;
  logic [STEPW-1:0] sat [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sat[j] = (prod7[j][53:32] > {4'b0, STEP_MAX}) ? STEP_MAX : prod7[j][49:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (unreach7) begin
        res8 <= '0;
      end else begin
        res8.reachable      <= 1'b1;
        res8.base_dir       <= dir7[0];
        res8.base_steps     <= sat[0];
        res8.shoulder_dir   <= dir7[1];
        res8.shoulder_steps <= sat[1];
        res8.elbow_dir      <= dir7[2];
        res8.elbow_steps    <= sat[2];
      end
    end
  end

  // Output register with one skid entry
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign adv  = ~skid_valid;
  assign take = out_valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (v8) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (v8) begin
      if (out_valid && !take) begin
        skid_data <= res8;
      end else begin
        out_data <= res8;
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.reachable      = out_data.reachable;
  assign result.base_dir       = out_data.base_dir;
  assign result.base_steps     = out_data.base_steps;
  assign result.shoulder_dir   = out_data.shoulder_dir;
  assign result.shoulder_steps = out_data.shoulder_steps;
  assign result.elbow_dir      = out_data.elbow_dir;
  assign result.elbow_steps    = out_data.elbow_steps;

endmodule

// ===== verif/aiks_checker.sv =====
module aiks_checker
  import aiks_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  aiks_target_if          target,
  aiks_result_if          result,
  aiks_cfg_if             cfg,
  output int              fail_count,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 16;

  // Configuration copy
  longint unsigned link_len;
  longint unsigned offset;
  longint unsigned spd;

  result_t expected_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC angle of (a, b), a >= 0, in 2^-24 degree
  function automatic longint vector_angle(longint a, longint b);
    longint ang;
    longint da;
    longint db;
    ang = 0;
    for (int i = 0; i < STAGES; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da;
        b -= db;
        ang += longint'(ATAN_DEG[i]);
      end else begin
        a -= da;
        b += db;
        ang -= longint'(ATAN_DEG[i]);
      end
    end
    return ang;
  endfunction

  function automatic void to_steps(longint ang, output logic dir,
                                   output logic [STEPW-1:0] steps);
    longint unsigned mag;
    longint unsigned s;
    mag = (ang < 0) ? longint'(-ang) : ang;
    s = (mag * spd) >> 32;
    dir = (ang < 0);
    steps = (s > 262143) ? STEP_MAX : s[STEPW-1:0];
  endfunction

  function automatic result_t solve_point(logic signed [13:0] tx,
                                          logic signed [13:0] ty,
                                          logic signed [13:0] tz);
    result_t res;
    longint x, y, z, ay, az, l, r0, rr, rs, h, yaw, half, a, th1, th2, th3;
    res = '0;
    x = longint'(tx) * 256;
    y = longint'(ty) * 256;
    z = longint'(tz) * 256;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    l = longint'(link_len) * 256;
    if (x == 0 && y == 0) return res;
    r0 = int_sqrt(x * x + y * y);
    rr = r0 - longint'(offset) * 256;
    if (rr < 0) rr = -rr;
    rs = int_sqrt(rr * rr + z * z);
    if (rs == 0 || rs > 2 * l) return res;
    h = int_sqrt(4 * l * l - rs * rs);
    yaw = vector_angle(ay, x);
    half = vector_angle(rs, h);
    a = vector_angle(az, rr);
    th1 = longint'(DEG90) - yaw;
    th2 = (z > 0) ? (a - half) : (longint'(DEG180) - a - half);
    th3 = 2 * half + th2 - longint'(DEG90);
    res.reachable = 1'b1;
    to_steps(th1, res.base_dir, res.base_steps);
    to_steps(th2, res.shoulder_dir, res.shoulder_steps);
    to_steps(th3, res.elbow_dir, res.elbow_steps);
    return res;
  endfunction

  assign pending = expected_q.size();

  // Track writes, predict accepted points, compare results
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      link_len <= 64'(LINK_LENGTH_RESET);
      offset <= 64'(BASE_OFFSET_RESET);
      spd <= 64'(STEPS_PER_DEGREE_RESET);
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LINK_LENGTH: begin
            link_len <= 64'(cfg.data[11:0]);
          end
          REG_BASE_OFFSET: begin
            offset <= 64'(cfg.data[11:0]);
          end
          REG_STEPS_PER_DEGREE: begin
            spd <= 64'(cfg.data);
          end
          default: ;
        endcase
      end
      if (target.valid && target.ready)
        expected_q.push_back(solve_point(target.target_x, target.target_y,
                                         target.target_z));
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if ({result.reachable, result.base_dir, result.base_steps,
               result.shoulder_dir, result.shoulder_steps, result.elbow_dir,
               result.elbow_steps} !== exp_r) begin
            fail_count <= fail_count + 1;
            if (result.reachable !== exp_r.reachable)
              $error("reachable exp %0d got %0d", exp_r.reachable, result.reachable);
            if (result.base_dir !== exp_r.base_dir)
              $error("base_dir exp %0d got %0d", exp_r.base_dir, result.base_dir);
            if (result.base_steps !== exp_r.base_steps)
              $error("base_steps exp %0d got %0d", exp_r.base_steps, result.base_steps);
            if (result.shoulder_dir !== exp_r.shoulder_dir)
              $error("shoulder_dir exp %0d got %0d", exp_r.shoulder_dir,
                     result.shoulder_dir);
            if (result.shoulder_steps !== exp_r.shoulder_steps)
              $error("shoulder_steps exp %0d got %0d", exp_r.shoulder_steps,
                     result.shoulder_steps);
            if (result.elbow_dir !== exp_r.elbow_dir)
              $error("elbow_dir exp %0d got %0d", exp_r.elbow_dir, result.elbow_dir);
            if (result.elbow_steps !== exp_r.elbow_steps)
              $error("elbow_steps exp %0d got %0d", exp_r.elbow_steps,
                     result.elbow_steps);
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb.sv =====
module tb
  import aiks_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 75 + 16;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  bit   calm;

  aiks_target_if target ();
  aiks_result_if result ();
  aiks_cfg_if    cfg ();

  arm_inverse_kinematics_steps_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .target (target),
    .result (result),
    .cfg    (cfg)
  );

  aiks_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .target     (target),
    .result     (result),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Limit
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver stalls now and then, never during the calm stretch
  initial begin
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Send one point, idling at random beforehand
  task automatic send_point(int x, int y, int z);
    while (!calm && $urandom_range(99) < 8) begin
      target.valid <= 1'b0;
      @(posedge clk);
    end
    target.valid <= 1'b1;
    target.target_x <= 14'(x);
    target.target_y <= 14'(y);
    target.target_z <= 14'(z);
    do @(posedge clk); while (!target.ready);
  endtask

  // Drop valid, then wait out every expected result plus latency
  task automatic drain();
    target.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_points(int count);
    logic signed [13:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      // Mostly points near the working range, some anywhere
      if ($urandom_range(3) == 0) begin
        x = 14'($urandom);
        y = 14'($urandom);
        z = 14'($urandom);
      end else begin
        x = $signed(14'($urandom_range(0, 8191))) - 14'sd4096;
        y = $signed(14'($urandom_range(0, 8191))) - 14'sd4096;
        z = $signed(14'($urandom_range(0, 8191))) - 14'sd4096;
      end
      send_point(int'(x), int'(y), int'(z));
    end
  endtask

  initial begin
    calm = 1'b0;
    rst = 1'b1;
    target.valid = 1'b0;
    target.target_x = '0;
    target.target_y = '0;
    target.target_z = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_LINK_LENGTH;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: origin, extremes, both z branches, offset beyond radius,
    // touching reach, out of reach
    send_point(0, 0, 0);
    send_point(0, 0, 1000);
    send_point(8191, 8191, 8191);
    send_point(-8192, -8192, -8192);
    send_point(-8192, 0, 0);
    send_point(0, 8191, 0);
    send_point(1000, 2000, 500);
    send_point(1000, 2000, -500);
    send_point(1000, 2000, 0);
    send_point(-1000, -2000, 1);
    send_point(100, 0, 300);
    send_point(0, 656, 0);
    send_point(0, 656 + 3840, 0);
    send_point(0, 656 + 3841, 0);
    send_point(0, -200, -1500);
    send_point(-1, 1, -1);
    drain();

    // Touching reach with small links, max steps per degree
    write_reg(REG_LINK_LENGTH, 20'd1);
    write_reg(REG_BASE_OFFSET, 20'd0);
    write_reg(REG_STEPS_PER_DEGREE, 20'hFFFFF);
    send_point(2, 0, 0);
    send_point(0, 2, 0);
    send_point(1, 1, 1);
    send_point(3, 0, 0);
    send_point(-1, 0, 0);
    drain();

    // Reset settings, calm stretch
    write_reg(REG_LINK_LENGTH, 20'(LINK_LENGTH_RESET));
    write_reg(REG_BASE_OFFSET, 20'(BASE_OFFSET_RESET));
    write_reg(REG_STEPS_PER_DEGREE, STEPS_PER_DEGREE_RESET);
    calm = 1'b1;
    random_points(150);
    calm = 1'b0;
    random_points(150);
    drain();

    // Largest link and offset, smallest steps per degree
    write_reg(REG_LINK_LENGTH, 20'd4095);
    write_reg(REG_BASE_OFFSET, 20'd4095);
    write_reg(REG_STEPS_PER_DEGREE, 20'd1);
    random_points(150);
    drain();

    // Mid settings
    write_reg(REG_LINK_LENGTH, 20'd3000);
    write_reg(REG_BASE_OFFSET, 20'd200);
    write_reg(REG_STEPS_PER_DEGREE, 20'd600000);
    random_points(150);
    drain();

    // Random settings per phase
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_LINK_LENGTH, 20'($urandom_range(1, 4095)));
      write_reg(REG_BASE_OFFSET, 20'($urandom_range(0, 4095)));
      write_reg(REG_STEPS_PER_DEGREE, 20'($urandom_range(1, 1048575)));
      random_points(100);
      drain();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
